@@ hdl/ssl_pkg.sv @@
// shared types and constants of the stream substring locator
`default_nettype none

package ssl_pkg;

  localparam int DEF_MAX_PATTERN = 16;
  localparam int DEF_COUNT_BITS  = 16;

  localparam int REG_CHARS  = 16;
  localparam int PIDX_BITS  = 4;
  localparam int LEN_BITS   = 5;
  localparam int ADDR_BITS  = 5;
  localparam int DATA_BITS  = 64;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  typedef enum logic [ADDR_BITS-1:0] {
    ADDR_PATTERN_LENGTH = 5'd0,
    ADDR_PATTERN_LOW    = 5'd8,
    ADDR_PATTERN_HIGH   = 5'd16
  } reg_addr_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       usable;
  } cell_link_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       care;
  } pat_slot_t;

  typedef struct packed {
    logic advance;
    logic flush;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/ssl_cell.sv @@
// one window cell: holds a character and its usable flag, compares against its pattern slot
`default_nettype none

module ssl_cell (
  input  wire                 clk,
  input  wire                 rst,
  input  ssl_pkg::cell_ctrl_t ctrl,
  input  ssl_pkg::cell_link_t link_in,
  input  ssl_pkg::pat_slot_t  slot,
  output ssl_pkg::cell_link_t link_out,
  output logic                ok
);
  import ssl_pkg::*;

  logic [7:0] ch;
  logic       usable;

  assign link_out.ch     = ch;
  assign link_out.usable = usable;

  // compare on the value about to shift in
  assign ok = ~slot.care | (link_in.usable & (link_in.ch == slot.ch));

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      ch <= link_in.ch;
    end
    if (rst) begin
      usable <= 1'b0;
    end else if (ctrl.flush) begin
      usable <= 1'b0;
    end else if (ctrl.advance) begin
      usable <= link_in.usable;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ssl_regs.sv @@
// configuration registers behind the apb port
`default_nettype none

module ssl_regs #(
  parameter int MAX_PATTERN = ssl_pkg::DEF_MAX_PATTERN
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [ssl_pkg::ADDR_BITS-1:0]     paddr,
  input  wire  [ssl_pkg::DATA_BITS-1:0]     pwdata,
  output logic [ssl_pkg::DATA_BITS-1:0]     prdata,
  output logic                              pready,
  output logic [ssl_pkg::LEN_BITS-1:0]      eff_len,
  output logic [ssl_pkg::REG_CHARS-1:0][7:0] pattern_chars
);
  import ssl_pkg::*;

  localparam int CAP = (MAX_PATTERN < REG_CHARS) ? MAX_PATTERN : REG_CHARS;

  logic [LEN_BITS-1:0]  pattern_length;
  logic [DATA_BITS-1:0] pattern_low;
  logic [DATA_BITS-1:0] pattern_high;
  logic                 wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      pattern_low    <= '0;
      pattern_high   <= '0;
    end else if (wr) begin
      unique case (reg_addr_t'(paddr))
        ADDR_PATTERN_LENGTH: pattern_length <= pwdata[LEN_BITS-1:0];
        ADDR_PATTERN_LOW:    pattern_low    <= pwdata;
        ADDR_PATTERN_HIGH:   pattern_high   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_addr_t'(paddr))
      ADDR_PATTERN_LENGTH: prdata = {{(DATA_BITS-LEN_BITS){1'b0}}, pattern_length};
      ADDR_PATTERN_LOW:    prdata = pattern_low;
      ADDR_PATTERN_HIGH:   prdata = pattern_high;
      default:             prdata = '0;
    endcase
  end

  assign pattern_chars = {pattern_high, pattern_low};
  assign eff_len = (pattern_length > LEN_BITS'(CAP)) ? LEN_BITS'(CAP) : pattern_length;

endmodule

`default_nettype wire

@@ hdl/stream_substring_locator.sv @@
// top level: window cell row, line and column counters, two-word result buffer
//
// usage:
//   input channel (in_valid/in_ready) takes one character word per ready cycle with
//   char_byte, first_in_file and file_number. output channel (out_valid/out_ready)
//   gives one word per non-overlapping pattern occurrence within a line:
//   match_file, match_row and match_column (column of the first pattern character).
//   the pattern is set over the apb port: pattern_length at 0x00, pattern_low at
//   0x08, pattern_high at 0x10; a length of zero disables matching.
//   throughput is one character per cycle while in_ready is high: the cell row
//   shifts and compares within the cycle a character is accepted. a result is
//   registered into the output word, or into the second buffer word while the
//   output word is held. a two-word result buffer sits between the sides;
//   in_ready drops only when both buffer words are held by a stalled receiver.
//   reset clears the pattern registers, the usable flags of the cells, sets
//   the row to one and the column to zero.
`default_nettype none

module stream_substring_locator #(
  parameter int MAX_PATTERN = ssl_pkg::DEF_MAX_PATTERN,
  parameter int COUNT_BITS  = ssl_pkg::DEF_COUNT_BITS
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire  [7:0]                    char_byte,
  input  wire                           first_in_file,
  input  wire  [7:0]                    file_number,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [7:0]                    match_file,
  output logic [15:0]                   match_row,
  output logic [15:0]                   match_column,
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire  [ssl_pkg::ADDR_BITS-1:0] paddr,
  input  wire  [ssl_pkg::DATA_BITS-1:0] pwdata,
  output logic [ssl_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready
);
  import ssl_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  typedef struct packed {
    logic [7:0]  file;
    logic [15:0] row;
    logic [15:0] column;
  } result_t;

  logic [LEN_BITS-1:0]        eff_len;
  logic [REG_CHARS-1:0][7:0]  pattern_chars;
  pat_slot_t                  slot     [MAX_PATTERN];
  cell_link_t                 link_in  [MAX_PATTERN];
  cell_link_t                 link_out [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]     ok;
  logic [MAX_PATTERN-1:0]     usable_vec;
  cell_ctrl_t                 ctrl;

  logic                       in_fire;
  logic                       is_nl;
  logic                       hit;
  logic [COUNT_BITS-1:0]      row;
  logic [COUNT_BITS-1:0]      column;
  logic [COUNT_BITS-1:0]      row_base;
  logic [COUNT_BITS-1:0]      col_base;
  logic [COUNT_BITS-1:0]      col_new;
  logic [COUNT_BITS-1:0]      start_col;
  result_t                    res_new;
  result_t                    res_out;
  result_t                    res_skid;
  logic                       skid_valid;
  logic                       pop;

  ssl_regs #(.MAX_PATTERN(MAX_PATTERN)) u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .eff_len       (eff_len),
    .pattern_chars (pattern_chars)
  );

  // pattern character aligned to each cell, newest character in the top cell
  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      slot[j].care = (j + int'(eff_len)) >= MAX_PATTERN;
      slot[j].ch   = pattern_chars[PIDX_BITS'(j + int'(eff_len) - MAX_PATTERN)];
    end
  end

  assign in_ready = ~skid_valid;
  assign in_fire  = in_valid & in_ready;
  assign is_nl    = (char_byte == NEWLINE_BYTE);

  genvar g;
  generate
    for (g = 0; g < MAX_PATTERN; g++) begin : g_cell
      if (g == MAX_PATTERN - 1) begin : g_top
        assign link_in[g].ch     = char_byte;
        assign link_in[g].usable = 1'b1;
      end else begin : g_mid
        assign link_in[g].ch     = link_out[g+1].ch;
        assign link_in[g].usable = link_out[g+1].usable & ~first_in_file;
      end
      assign usable_vec[g] = link_out[g].usable;

      ssl_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .link_in  (link_in[g]),
        .slot     (slot[g]),
        .link_out (link_out[g]),
        .ok       (ok[g])
      );
    end
  endgenerate

  assign hit          = in_fire & ~is_nl & (eff_len != '0) & (&ok);
  assign ctrl.advance = in_fire & ~is_nl;
  assign ctrl.flush   = (in_fire & is_nl) | hit;

  // line and column counters
  assign row_base  = first_in_file ? COUNT_ONE : row;
  assign col_base  = first_in_file ? '0 : column;
  assign col_new   = (col_base < COUNT_MAX) ? col_base + COUNT_ONE : COUNT_MAX;
  assign start_col = col_new - COUNT_BITS'(eff_len) + COUNT_ONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      row    <= COUNT_ONE;
      column <= '0;
    end else if (in_fire) begin
      if (is_nl) begin
        row    <= (row_base < COUNT_MAX) ? row_base + COUNT_ONE : COUNT_MAX;
        column <= '0;
      end else begin
        row    <= row_base;
        column <= col_new;
      end
    end
  end

  assign res_new.file   = file_number;
  assign res_new.row    = 16'(row_base);
  assign res_new.column = 16'(start_col);

  // two-word result buffer
  assign pop = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        res_out    <= res_skid;
        skid_valid <= 1'b0;
      end
    end else if (hit) begin
      if (!out_valid || pop) begin
        res_out   <= res_new;
        out_valid <= 1'b1;
      end else begin
        res_skid   <= res_new;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign match_file   = res_out.file;
  assign match_row    = res_out.row;
  assign match_column = res_out.column;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held without output word");

  a_nl_clears_column: assert property (@(posedge clk) disable iff (rst)
    (in_fire && is_nl) |=> (column == '0))
    else $error("column not cleared after newline");

  a_hit_flushes_cells: assert property (@(posedge clk) disable iff (rst)
    hit |=> (usable_vec == '0))
    else $error("cells still usable after a match");

  a_hit_gives_word: assert property (@(posedge clk) disable iff (rst)
    hit |=> out_valid)
    else $error("match produced no output word");

endmodule

`default_nettype wire
